// ----- design/clrs_pkg.sv -----
package clrs_pkg;

  localparam int ModeW = 2;
  localparam int ByteW = 8;

  localparam logic [ModeW-1:0] MODE_TICK  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  localparam logic [ByteW-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ByteW-1:0] TICK_DIV_RST = 8'd3;

  // Low control nibble of character bytes: E=1/RS=1 and E=0/RS=1
  localparam logic [3:0] CTRL_E_RS = 4'hb;
  localparam logic [3:0] CTRL_RS   = 4'h3;

  // Set-address sequence, one row per line, indexed by phase[1:0]
  typedef logic [3:0][ByteW-1:0] addr_row_t;

  function automatic logic [ByteW-1:0] addr_byte(input logic line, input logic [1:0] ph);
    addr_row_t row;
    row = line ? {8'h01, 8'h09, 8'hc1, 8'hc9} : {8'h01, 8'h09, 8'h81, 8'h89};
    return row[ph];
  endfunction

endpackage

// ----- design/char_lcd_refresh_sequencer.sv -----
// Character LCD refresh sequencer.
// Input channel (in_valid_i/in_ready_o) carries requests: mode_i = tick,
// write buffer character (char_index_i, char_value_i) or clear buffer.
// Every tick_divide-th tick emits one expander byte on the output channel
// (out_valid_o/out_ready_i): spi_byte_o and frame_end_o, the latter set on
// the last byte of line two. Writes, clears and other ticks emit nothing.
// A request is taken into an input register, then processed into the output
// register. One request per cycle is accepted while the output is drained.
// If the receiver stalls, the output register holds and the input
// register fills; in_ready_o drops until out_ready_i returns.
// Reset (rst_ni low, async) sets tick_divide to 3, the buffer to spaces,
// and starts the sequence at line one's address command.
// cfg_we_i/cfg_data_i write tick_divide; write only while idle.
// Buffer positions at or beyond 2*LINE_LEN are ignored on write.
module char_lcd_refresh_sequencer #(
  parameter int LINE_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [4:0] char_index_i,
  input  logic [7:0] char_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] spi_byte_o,
  output logic       frame_end_o
);

  localparam int BufDepth = 2 * LINE_LEN;
  localparam int Store    = (BufDepth < 32) ? BufDepth : 32;
  localparam int IdxW     = $clog2(Store);
  localparam int PosW     = $clog2(BufDepth);
  localparam int PtrW     = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam logic [PosW:0] StoreP    = (PosW + 1)'(Store);
  localparam logic [6:0]    BufDepthC = 7'(BufDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(LINE_LEN - 1);
  localparam logic [PosW-1:0] LineOff = PosW'(LINE_LEN);

  // configuration
  logic [7:0] tick_div_q;

  // input register
  logic       req_valid_q;
  logic [1:0] req_mode_q;
  logic [4:0] req_idx_q;
  logic [7:0] req_val_q;

  // sequencer state
  logic [7:0]      tick_cnt_q, tick_cnt_d;
  logic [2:0]      phase_q, phase_d;
  logic            line_q, line_d;
  logic [PtrW-1:0] ptr_q, ptr_d;

  // character store with per-entry valid (invalid reads as space)
  logic [7:0]       buf_mem_q [Store];
  logic [Store-1:0] buf_vld_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       fend_q, fend_d;

  logic            advance;
  logic            proc;
  logic            is_tick;
  logic            emit;
  logic [7:0]      cnt_inc;
  logic [PosW-1:0] pos;
  logic [7:0]      chr;
  logic            wr_en;

  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  assign is_tick = (req_mode_q == clrs_pkg::MODE_TICK);
  assign cnt_inc = tick_cnt_q + 8'd1;
  assign emit    = proc && is_tick && !(cnt_inc < tick_div_q);
  assign wr_en   = proc && (req_mode_q == clrs_pkg::MODE_WRITE)
                   && ({2'b00, req_idx_q} < BufDepthC);

  assign pos = line_q ? (LineOff + PosW'(ptr_q)) : PosW'(ptr_q);

  always_comb begin
    chr = clrs_pkg::SPACE_CODE;
    if ({1'b0, pos} < StoreP) begin
      if (buf_vld_q[pos[IdxW-1:0]]) begin
        chr = buf_mem_q[pos[IdxW-1:0]];
      end
    end
  end

  always_comb begin
    tick_cnt_d  = tick_cnt_q;
    phase_d     = phase_q;
    line_d      = line_q;
    ptr_d       = ptr_q;
    byte_d      = byte_q;
    fend_d      = fend_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (proc && is_tick) begin
      tick_cnt_d = emit ? 8'd0 : cnt_inc;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      fend_d      = 1'b0;
      if (!phase_q[2]) begin
        byte_d  = clrs_pkg::addr_byte(line_q, phase_q[1:0]);
        phase_d = phase_q + 3'd1;
      end else begin
        byte_d = {phase_q[1] ? chr[3:0] : chr[7:4],
                  phase_q[0] ? clrs_pkg::CTRL_RS : clrs_pkg::CTRL_E_RS};
        if (phase_q != 3'd7) begin
          phase_d = phase_q + 3'd1;
        end else if (ptr_q != PtrLast) begin
          ptr_d   = ptr_q + 1'b1;
          phase_d = 3'd4;
        end else begin
          ptr_d   = '0;
          phase_d = 3'd0;
          fend_d  = line_q;
          line_d  = !line_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q  <= clrs_pkg::TICK_DIV_RST;
      req_valid_q <= 1'b0;
      tick_cnt_q  <= '0;
      phase_q     <= '0;
      line_q      <= 1'b0;
      ptr_q       <= '0;
      buf_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_div_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      tick_cnt_q  <= tick_cnt_d;
      phase_q     <= phase_d;
      line_q      <= line_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (proc && (req_mode_q == clrs_pkg::MODE_CLEAR)) begin
        buf_vld_q <= '0;
      end else if (wr_en) begin
        buf_vld_q[req_idx_q[IdxW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_mode_q <= mode_i;
      req_idx_q  <= char_index_i;
      req_val_q  <= char_value_i;
    end
    if (wr_en) begin
      buf_mem_q[req_idx_q[IdxW-1:0]] <= req_val_q;
    end
    byte_q <= byte_d;
    fend_q <= fend_d;
  end

  assign out_valid_o = out_valid_q;
  assign spi_byte_o  = byte_q;
  assign frame_end_o = fend_q;

  // A stalled result is never overwritten by a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !emit)
    else $error("result overwritten while stalled");

  // Address phases always start a line at its first character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q[2] |-> ptr_q == '0)
    else $error("pointer not cleared during address phases");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrLast)
    else $error("character pointer past line end");

  // Frame end only on a trailing E-low byte of a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fend_q |-> byte_q[3:0] == clrs_pkg::CTRL_RS)
    else $error("frame end on wrong byte");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int LineLen    = 16;
  localparam int BufDepth   = 2 * LineLen;
  localparam int CycleLimit = 200000;
  localparam int HoldAtByte = 150;
  localparam int HoldCycles = 300;
  localparam int NumPhases  = 5;

  localparam logic [clrs_pkg::ModeW-1:0] MODE_NONE = 2'd3;
  // address command nibbles: RS=0, blink set, E high then low
  localparam logic [3:0] CTRL_ADDR_E = 4'h9;
  localparam logic [3:0] CTRL_ADDR   = 4'h1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [7:0] spi;
    logic       fend;
  } lcd_out_t;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] mode;
    logic [4:0] idx;
    logic [7:0] val;    // divider value on ROW_CFG
    logic       typed;
    lcd_out_t   res;
  } dir_row_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic [7:0] cfg_data_i   = '0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i       = clrs_pkg::MODE_TICK;
  logic [4:0] char_index_i = '0;
  logic [7:0] char_value_i = '0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] spi_byte_o;
  logic       frame_end_o;

  // shadow of the sequencer state
  logic [7:0] lcd_div;
  logic [7:0] lcd_ticks;
  logic [7:0] lcd_chars [BufDepth];
  logic [2:0] lcd_phase;
  logic       lcd_line;
  int         lcd_ptr;

  lcd_out_t   pending_bytes [$];
  dir_row_t   dir_rows [$];
  bit         tx_idle;
  int         errors   = 0;
  int         n_req    = 0;
  int         n_bytes  = 0;
  int         n_frames = 0;
  int         cycles   = 0;

  logic [7:0] phase_div [NumPhases] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3};
  int         phase_len [NumPhases] = '{500, 520, 250, 200, 150};
  int         phase_pct [NumPhases] = '{80, 98, 80, 75, 85};

  char_lcd_refresh_sequencer #(
    .LINE_LEN(LineLen)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .char_index_i(char_index_i),
    .char_value_i(char_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .spi_byte_o  (spi_byte_o),
    .frame_end_o (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  function automatic void lcd_clear();
    for (int i = 0; i < BufDepth; i++) lcd_chars[i] = clrs_pkg::SPACE_CODE;
  endfunction

  // Advances the shadow state by one request; returns 1 when a byte goes out.
  function automatic bit lcd_advance(input logic [1:0] mode, input logic [4:0] idx,
                                     input logic [7:0] val, output lcd_out_t res);
    logic [7:0] c;
    res = '0;
    if (mode == clrs_pkg::MODE_WRITE) begin
      if (idx < BufDepth) lcd_chars[idx] = val;
      return 1'b0;
    end
    if (mode == clrs_pkg::MODE_CLEAR) begin
      lcd_clear();
      return 1'b0;
    end
    if (mode != clrs_pkg::MODE_TICK) return 1'b0;
    lcd_ticks = lcd_ticks + 8'd1;
    if (lcd_ticks < lcd_div) return 1'b0;
    lcd_ticks = '0;
    if (lcd_phase < 3'd4) begin
      res.spi[7:4] = (lcd_phase < 3'd2) ? (lcd_line ? 4'hc : 4'h8) : 4'h0;
      res.spi[3:0] = lcd_phase[0] ? CTRL_ADDR : CTRL_ADDR_E;
      lcd_phase = lcd_phase + 3'd1;
    end else begin
      c = lcd_chars[lcd_line * LineLen + lcd_ptr];
      res.spi[7:4] = lcd_phase[1] ? c[3:0] : c[7:4];
      res.spi[3:0] = lcd_phase[0] ? clrs_pkg::CTRL_RS : clrs_pkg::CTRL_E_RS;
      if (lcd_phase != 3'd7) begin
        lcd_phase = lcd_phase + 3'd1;
      end else if (lcd_ptr + 1 < LineLen) begin
        lcd_ptr++;
        lcd_phase = 3'd4;
      end else begin
        lcd_ptr   = 0;
        lcd_phase = 3'd0;
        res.fend  = lcd_line;
        lcd_line  = ~lcd_line;
      end
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(input row_kind_e kind, input logic [1:0] mode,
                                      input logic [4:0] idx, input logic [7:0] val,
                                      input logic typed, input logic [7:0] spi);
    dir_row_t row;
    row.kind     = kind;
    row.mode     = mode;
    row.idx      = idx;
    row.val      = val;
    row.typed    = typed;
    row.res.spi  = spi;
    row.res.fend = 1'b0;
    return row;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_req(input logic [1:0] mode, input logic [4:0] idx,
                          input logic [7:0] val, input logic typed,
                          input lcd_out_t typed_res);
    int       gap;
    lcd_out_t res;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    char_index_i <= idx;
    char_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_req++;
    if (lcd_advance(mode, idx, val, res) || typed)
      pending_bytes.push_back(typed ? typed_res : res);
  endtask

  // A tick that emits nothing may still be in flight, hence the extra cycles.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_divider(input logic [7:0] div);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= div;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lcd_div = div;
  endtask

  // receiver: checks bytes in order, stalls at random, one long hold
  initial begin
    int       rx_wait;
    int       rx_cnt;
    bit       rx_idle;
    lcd_out_t want;
    rx_wait = 0;
    rx_cnt  = 0;
    rx_idle = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cnt++;
      if (rx_cnt % 64 == 0) rx_idle = 1'($urandom_range(0, 1));
      if (out_valid_o && out_ready_i) begin
        n_bytes++;
        if (frame_end_o) n_frames++;
        if (pending_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte %02h frame_end %0b, none expected",
                   $time, spi_byte_o, frame_end_o);
        end else begin
          want = pending_bytes.pop_front();
          if (spi_byte_o !== want.spi) begin
            errors++;
            $display("%0t: spi_byte expected %02h got %02h", $time, want.spi, spi_byte_o);
          end
          if (frame_end_o !== want.fend) begin
            errors++;
            $display("%0t: frame_end expected %0b got %0b", $time, want.fend, frame_end_o);
          end
        end
        if (n_bytes == HoldAtByte) rx_wait = HoldCycles;
        else rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [1:0] mode;
    logic [4:0] idx;
    logic [7:0] val;
    int         r;
    int         sel;
    int         t0;

    lcd_div   = clrs_pkg::TICK_DIV_RST;
    lcd_ticks = '0;
    lcd_phase = '0;
    lcd_line  = 1'b0;
    lcd_ptr   = 0;
    lcd_clear();

    // reset divider 3: every third tick emits
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h89));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd31, 8'hff, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd31, 8'hff, 1'b0, 8'h00));
    // divider dropped below the running count: next tick emits at once
    dir_rows.push_back(mk_row(ROW_CFG, clrs_pkg::MODE_TICK,  5'd0,  8'd1,  1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h81));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h09));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_WRITE, 5'd0,  8'ha5, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_WRITE, 5'd31, 8'hff, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, MODE_NONE,            5'd31, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_WRITE, 5'd16, 8'h3c, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h01));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_CLEAR, 5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h2b));
    // divider zero acts as one
    dir_rows.push_back(mk_row(ROW_CFG, clrs_pkg::MODE_TICK,  5'd0,  8'd0,  1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b1, 8'h23));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));
    dir_rows.push_back(mk_row(ROW_REQ, clrs_pkg::MODE_TICK,  5'd0,  8'h00, 1'b0, 8'h00));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) set_divider(dir_rows[i].val);
      else send_req(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val,
                    dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_divider(phase_div[p]);
      for (int k = 0; k < phase_len[p]; k++) begin
        if (k % 50 == 0) tx_idle = 1'($urandom_range(0, 1));
        // sender pauses until the output side has drained
        if (k == phase_len[p] / 2) wait_idle();
        r   = $urandom_range(0, 99);
        idx = 5'($urandom_range(0, 31));
        val = 8'($urandom_range(0, 255));
        if (r < phase_pct[p]) begin
          mode = clrs_pkg::MODE_TICK;
        end else begin
          sel  = $urandom_range(0, 19);
          mode = (sel == 0) ? clrs_pkg::MODE_CLEAR :
                 (sel == 1) ? MODE_NONE : clrs_pkg::MODE_WRITE;
        end
        send_req(mode, idx, val, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    t0 = cycles;
    while (pending_bytes.size() != 0 && cycles - t0 < 2000) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
    end

    $display("Ran %0d requests (ticks, writes, clears, unused mode), %0d bytes checked,",
             n_req, n_bytes);
    $display("%0d full frames, dividers reset/0/1/2/3/255, long output stall.", n_frames);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/clrs_pkg.sv
design/char_lcd_refresh_sequencer.sv
tb/tb.sv
